[src/tve_pkg.sv]
`default_nettype none

package tve_pkg;

    // Default sizes of the touch table and of each sample ring.
    localparam int MAX_TOUCHES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 8;

    // Field widths.
    localparam int ID_W    = 16;
    localparam int POS_W16 = 16;
    localparam int STAMP_W = 10;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = $clog2(VAL_W);

    localparam logic [STAMP_W-1:0] MIN_INTERVAL_RST = 10'd10;
    localparam logic signed [11:0] MS_WRAP          = 12'sd1000;

    // Event kinds.
    localparam logic [1:0] MODE_DOWN  = 2'd0;
    localparam logic [1:0] MODE_MOVE  = 2'd1;
    localparam logic [1:0] MODE_UP    = 2'd2;
    localparam logic [1:0] MODE_OTHER = 2'd3;

    // Register index of min_interval_ms.
    localparam logic REG_MIN_INTERVAL = 1'b0;

    typedef enum logic [2:0] {
        ST_KEPT      = 3'd0,
        ST_THROTTLED = 3'd1,
        ST_ESTIMATE  = 3'd2,
        ST_TOO_FEW   = 3'd3,
        ST_DUPLICATE = 3'd4,
        ST_UNKNOWN   = 3'd5,
        ST_FULL      = 3'd6,
        ST_IGNORED   = 3'd7
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DISPATCH,
        S_KEEP,
        S_UP_START,
        S_WALK,
        S_DIV,
        S_DIV_DONE,
        S_FINISH
    } t_state;

    // What the shared divider is working on.
    typedef enum logic [2:0] {
        OP_VX,
        OP_VY,
        OP_AX,
        OP_AY,
        OP_MVX,
        OP_MVY,
        OP_MAX,
        OP_MAY
    } t_op;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [POS_W16-1:0] y;
        logic [POS_W16-1:0] x;
    } t_sample;

    // Time from prev to cur in ms, wrapping at one second.
    function automatic logic [STAMP_W-1:0] f_elapsed(input logic [STAMP_W-1:0] prev,
                                                     input logic [STAMP_W-1:0] cur);
        logic signed [11:0] d;
        d = $signed({2'b00, cur}) - $signed({2'b00, prev});
        if (d < 0) begin
            d = d + MS_WRAP;
        end
        if (d < 0) begin
            d = d + MS_WRAP;
        end
        return d[STAMP_W-1:0];
    endfunction

endpackage

`default_nettype wire

[src/touch_velocity_estimator_core.sv]
`default_nettype none

// Touch velocity estimator. Each event beat (kind in tuser, id, x, y and ms
// stamp in tdata) is handled one at a time by a small sequencer around one
// shared restoring divider that retires one quotient bit per cycle. Every
// event first scans the slot table, reading and then comparing one slot
// entry at a time until it finds a match or reaches the last slot. Each
// division produces all 32 quotient bits and then collects the result. An
// up that reports an estimate over n kept samples runs two divisions for the
// first sample pair, four for each later pair and four for the final means.
// The next event is taken while the previous result beat still waits on the
// output register.
module touch_velocity_estimator_core
    import tve_pkg::*;
#(
    parameter int MAX_TOUCHES = MAX_TOUCHES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Event stream.
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [63:0]  i_s_tdata,   // touch_id, pos_x, pos_y, stamp_ms, zero pad
    input  wire logic [1:0]   i_s_tuser,   // mode
    // Result stream.
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [127:0]      o_m_tdata,   // mean_vel_x, mean_vel_y, mean_acc_x, mean_acc_y
    output logic [2:0]        o_m_tuser,   // status
    // Register port.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int SW     = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;
    localparam int POS_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(MAX_TOUCHES * QUEUE_DEPTH);

    // Memory address of ring entry i of a slot.
    function automatic logic [ADDR_W-1:0] f_pos(input logic [SW-1:0] slot,
                                               input logic [POS_W-1:0] start,
                                               input logic [FILL_W-1:0] i);
        logic [FILL_W+1:0] idx;
        idx = (FILL_W+2)'(start) + (FILL_W+2)'(i);
        if (idx >= (FILL_W+2)'(QUEUE_DEPTH)) begin
            idx = idx - (FILL_W+2)'(QUEUE_DEPTH);
        end
        return ADDR_W'(slot) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(idx);
    endfunction

    function automatic logic [VAL_W-1:0] f_abs(input logic signed [VAL_W-1:0] a);
        return a[VAL_W-1] ? VAL_W'(-a) : a;
    endfunction

    // Register port.
    logic [STAMP_W-1:0] r_min;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_MIN_INTERVAL) ? {22'd0, r_min} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_INTERVAL_RST;
        end else if (cfg_wr && paddr[2] == REG_MIN_INTERVAL) begin
            r_min <= pwdata[STAMP_W-1:0];
        end
    end

    // Slot table memory (id, ring start, ring fill) and sample memory.
    logic [ID_W-1:0]   sl_id_mem    [MAX_TOUCHES];
    logic [POS_W-1:0]  sl_start_mem [MAX_TOUCHES];
    logic [FILL_W-1:0] sl_fill_mem  [MAX_TOUCHES];
    t_sample           sm_mem       [MAX_TOUCHES*QUEUE_DEPTH];

    logic [ID_W-1:0]   r_sl_id_rd;
    logic [POS_W-1:0]  r_sl_start_rd;
    logic [FILL_W-1:0] r_sl_fill_rd;
    t_sample           r_sm_rd;

    logic              sl_we;
    logic [SW-1:0]     sl_waddr;
    logic [ID_W-1:0]   sl_wid;
    logic [POS_W-1:0]  sl_wstart;
    logic [FILL_W-1:0] sl_wfill;
    logic              sm_we;
    logic [ADDR_W-1:0] sm_waddr;
    logic [ADDR_W-1:0] sm_raddr;
    t_sample           sm_wdata;

    // Sequencer registers.
    t_state             r_state, n_state;
    logic [1:0]         r_mode, n_mode;
    logic [ID_W-1:0]    r_id, n_id;
    t_sample            r_in, n_in;
    logic [SW-1:0]      r_scan, n_scan;
    logic [SW-1:0]      r_slot, n_slot;
    logic               r_has_free, n_has_free;
    logic [SW-1:0]      r_free, n_free;
    logic [POS_W-1:0]   r_start, n_start;
    logic [FILL_W-1:0]  r_fill, n_fill;
    logic [MAX_TOUCHES-1:0] r_in_use, n_in_use;
    logic [FILL_W-1:0]  r_k, n_k;
    t_sample            r_prev, n_prev;
    t_sample            r_cur, n_cur;
    logic [STAMP_W-1:0] r_dt, n_dt;
    logic signed [VAL_W-1:0] r_vx, n_vx, r_vy, n_vy, r_pvx, n_pvx, r_pvy, n_pvy;
    logic signed [VAL_W-1:0] r_svx, n_svx, r_svy, n_svy, r_sax, n_sax, r_say, n_say;
    logic signed [VAL_W-1:0] r_rvx, n_rvx, r_rvy, n_rvy, r_rax, n_rax, r_ray, n_ray;
    t_status            r_status, n_status;
    // Shared divider.
    logic [VAL_W-1:0]   r_quo, n_quo;
    logic [STAMP_W-1:0] r_rem, n_rem;
    logic [STAMP_W-1:0] r_dvs, n_dvs;
    logic               r_neg, n_neg;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_op                r_op, n_op;
    // Output register.
    logic               r_o_valid, n_o_valid;
    logic [2:0]         r_o_user, n_o_user;
    logic [127:0]       r_o_data, n_o_data;

    // Combinational helpers.
    logic               div_go;
    logic signed [VAL_W-1:0] div_a;
    logic [STAMP_W-1:0] div_b;
    t_op                div_op;
    logic [STAMP_W:0]   rem2;
    logic               ge;
    logic signed [VAL_W-1:0] q;
    logic [STAMP_W-1:0] el;
    logic [POS_W-1:0]   ks;
    logic [FILL_W-1:0]  kf;
    logic signed [16:0] dx;
    logic [FILL_W-1:0]  nk;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_user;
    assign o_m_tdata  = r_o_data;

    // Memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (sl_we) begin
            sl_id_mem[sl_waddr]    <= sl_wid;
            sl_start_mem[sl_waddr] <= sl_wstart;
            sl_fill_mem[sl_waddr]  <= sl_wfill;
        end
        r_sl_id_rd    <= sl_id_mem[r_scan];
        r_sl_start_rd <= sl_start_mem[r_scan];
        r_sl_fill_rd  <= sl_fill_mem[r_scan];
    end

    always_ff @(posedge i_clk) begin
        if (sm_we) begin
            sm_mem[sm_waddr] <= sm_wdata;
        end
        r_sm_rd <= sm_mem[sm_raddr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_in_use  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_in_use  <= n_in_use;
            r_o_valid <= n_o_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_id       <= n_id;
        r_in       <= n_in;
        r_scan     <= n_scan;
        r_slot     <= n_slot;
        r_has_free <= n_has_free;
        r_free     <= n_free;
        r_start    <= n_start;
        r_fill     <= n_fill;
        r_k        <= n_k;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_dt       <= n_dt;
        r_vx       <= n_vx;
        r_vy       <= n_vy;
        r_pvx      <= n_pvx;
        r_pvy      <= n_pvy;
        r_svx      <= n_svx;
        r_svy      <= n_svy;
        r_sax      <= n_sax;
        r_say      <= n_say;
        r_rvx      <= n_rvx;
        r_rvy      <= n_rvy;
        r_rax      <= n_rax;
        r_ray      <= n_ray;
        r_status   <= n_status;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_dvs      <= n_dvs;
        r_neg      <= n_neg;
        r_cnt      <= n_cnt;
        r_op       <= n_op;
        r_o_user   <= n_o_user;
        r_o_data   <= n_o_data;
    end

    // Sequencer: next state, memory access and divider control.
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_id       = r_id;
        n_in       = r_in;
        n_scan     = r_scan;
        n_slot     = r_slot;
        n_has_free = r_has_free;
        n_free     = r_free;
        n_start    = r_start;
        n_fill     = r_fill;
        n_in_use   = r_in_use;
        n_k        = r_k;
        n_prev     = r_prev;
        n_cur      = r_cur;
        n_dt       = r_dt;
        n_vx       = r_vx;
        n_vy       = r_vy;
        n_pvx      = r_pvx;
        n_pvy      = r_pvy;
        n_svx      = r_svx;
        n_svy      = r_svy;
        n_sax      = r_sax;
        n_say      = r_say;
        n_rvx      = r_rvx;
        n_rvy      = r_rvy;
        n_rax      = r_rax;
        n_ray      = r_ray;
        n_status   = r_status;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_dvs      = r_dvs;
        n_neg      = r_neg;
        n_cnt      = r_cnt;
        n_op       = r_op;
        n_o_valid  = r_o_valid;
        n_o_user   = r_o_user;
        n_o_data   = r_o_data;

        sl_we     = 1'b0;
        sl_waddr  = r_slot;
        sl_wid    = r_id;
        sl_wstart = r_start;
        sl_wfill  = r_fill;
        sm_we     = 1'b0;
        sm_waddr  = f_pos(r_slot, r_start, r_fill);
        sm_wdata  = r_in;
        sm_raddr  = f_pos(r_slot, r_start, r_k);

        div_go = 1'b0;
        div_a  = '0;
        div_b  = r_dt;
        div_op = OP_VX;

        rem2 = {r_rem, r_quo[VAL_W-1]};
        ge   = (rem2 >= {1'b0, r_dvs});
        q    = r_neg ? -$signed(r_quo) : $signed(r_quo);
        el   = f_elapsed(r_sm_rd.stamp, r_in.stamp);
        ks   = r_start;
        kf   = r_fill;
        dx   = $signed({1'b0, r_sm_rd.x}) - $signed({1'b0, r_prev.x});
        nk   = r_k + 1'b1;

        // The result beat leaves when the sink takes it.
        if (r_o_valid && i_m_tready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_mode     = i_s_tuser;
                    n_id       = i_s_tdata[15:0];
                    n_in.x     = i_s_tdata[31:16];
                    n_in.y     = i_s_tdata[47:32];
                    n_in.stamp = i_s_tdata[57:48];
                    n_scan     = '0;
                    n_has_free = 1'b0;
                    n_rvx      = '0;
                    n_rvy      = '0;
                    n_rax      = '0;
                    n_ray      = '0;
                    n_state    = S_SCAN_RD;
                end
            end

            // Read one slot entry per visit.
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end

            S_SCAN_CMP: begin
                if (r_in_use[r_scan] && r_sl_id_rd == r_id) begin
                    n_slot  = r_scan;
                    n_start = r_sl_start_rd;
                    n_fill  = r_sl_fill_rd;
                    n_state = S_DISPATCH;
                end else begin
                    if (!r_in_use[r_scan] && !r_has_free) begin
                        n_has_free = 1'b1;
                        n_free     = r_scan;
                    end
                    // Past the last slot with no match.
                    if (r_scan == SW'(MAX_TOUCHES - 1)) begin
                        n_slot  = r_free;
                        n_state = S_DISPATCH;
                        if (r_mode == MODE_DOWN) begin
                            n_slot = (!r_in_use[r_scan] && !r_has_free) ? r_scan : r_free;
                            n_has_free = r_has_free | ~r_in_use[r_scan];
                        end
                        n_fill = '0;
                    end else begin
                        n_scan  = r_scan + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
                // Remember whether the scan ended on a match.
                n_k = (r_in_use[r_scan] && r_sl_id_rd == r_id) ? FILL_W'(1) : '0;
            end

            S_DISPATCH: begin
                sm_raddr = f_pos(r_slot, r_start, r_fill - 1'b1);
                if (r_mode == MODE_DOWN) begin
                    n_state = S_FINISH;
                    if (r_k != '0) begin
                        n_status = ST_DUPLICATE;
                    end else if (!r_has_free) begin
                        n_status = ST_FULL;
                    end else begin
                        n_in_use[r_slot] = 1'b1;
                        sl_we     = 1'b1;
                        sl_wstart = '0;
                        sl_wfill  = FILL_W'(1);
                        sm_we     = 1'b1;
                        sm_waddr  = f_pos(r_slot, '0, '0);
                        n_status  = ST_KEPT;
                    end
                end else if (r_mode == MODE_MOVE || r_mode == MODE_UP) begin
                    if (r_k == '0) begin
                        n_status = ST_UNKNOWN;
                        n_state  = S_FINISH;
                    end else begin
                        n_state = S_KEEP;
                    end
                end else begin
                    n_status = ST_IGNORED;
                    n_state  = S_FINISH;
                end
            end

            // Keep the event's sample if enough time has passed.
            S_KEEP: begin
                if (el <= r_min) begin
                    n_status = ST_THROTTLED;
                end else begin
                    if (r_fill >= FILL_W'(QUEUE_DEPTH)) begin
                        ks = (r_start == POS_W'(QUEUE_DEPTH - 1)) ? '0 : r_start + 1'b1;
                        kf = FILL_W'(QUEUE_DEPTH - 1);
                    end
                    sm_we     = 1'b1;
                    sm_waddr  = f_pos(r_slot, ks, kf);
                    n_start   = ks;
                    n_fill    = kf + 1'b1;
                    sl_we     = 1'b1;
                    sl_wstart = ks;
                    sl_wfill  = kf + 1'b1;
                    n_status  = ST_KEPT;
                end
                n_state = (r_mode == MODE_UP) ? S_UP_START : S_FINISH;
            end

            S_UP_START: begin
                n_in_use[r_slot] = 1'b0;
                sm_raddr = f_pos(r_slot, r_start, '0);
                n_k   = '0;
                n_svx = '0;
                n_svy = '0;
                n_sax = '0;
                n_say = '0;
                if (r_fill < FILL_W'(3)) begin
                    n_status = ST_TOO_FEW;
                    n_state  = S_FINISH;
                end else begin
                    n_state = S_WALK;
                end
            end

            // Sample k is in the read register.
            S_WALK: begin
                if (r_k == '0) begin
                    n_prev   = r_sm_rd;
                    n_k      = FILL_W'(1);
                    sm_raddr = f_pos(r_slot, r_start, FILL_W'(1));
                end else begin
                    n_cur  = r_sm_rd;
                    n_dt   = f_elapsed(r_prev.stamp, r_sm_rd.stamp);
                    if (n_dt == '0) begin
                        n_dt = STAMP_W'(1);
                    end
                    div_go = 1'b1;
                    div_a  = {{7{dx[16]}}, dx, 8'd0};
                    div_b  = n_dt;
                    div_op = OP_VX;
                end
            end

            // One quotient bit per cycle.
            S_DIV: begin
                n_rem = ge ? STAMP_W'(rem2 - {1'b0, r_dvs}) : rem2[STAMP_W-1:0];
                n_quo = {r_quo[VAL_W-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(VAL_W - 1)) begin
                    n_state = S_DIV_DONE;
                end
            end

            S_DIV_DONE: begin
                unique case (r_op)
                    OP_VX: begin
                        n_vx   = q;
                        n_svx  = r_svx + q;
                        div_go = 1'b1;
                        div_a  = VAL_W'($signed({1'b0, r_cur.y}) - $signed({1'b0, r_prev.y}))
                                 <<< 8;
                        div_op = OP_VY;
                    end
                    OP_VY: begin
                        n_vy  = q;
                        n_svy = r_svy + q;
                        if (r_k >= FILL_W'(2)) begin
                            div_go = 1'b1;
                            div_a  = r_vx - r_pvx;
                            div_op = OP_AX;
                        end else begin
                            n_state = S_DIV_DONE;
                            n_op    = OP_AY;
                            n_quo   = '0;
                            n_neg   = 1'b0;
                        end
                    end
                    OP_AX: begin
                        n_sax  = r_sax + q;
                        div_go = 1'b1;
                        div_a  = r_vy - r_pvy;
                        div_op = OP_AY;
                    end
                    OP_AY: begin
                        // End of one sample pair; zero is added when no
                        // acceleration was taken for it.
                        n_say  = r_say + q;
                        n_pvx  = r_vx;
                        n_pvy  = r_vy;
                        n_prev = r_cur;
                        n_k    = nk;
                        if (nk == r_fill) begin
                            div_go = 1'b1;
                            div_a  = r_svx;
                            div_b  = STAMP_W'(r_fill - 1'b1);
                            div_op = OP_MVX;
                        end else begin
                            sm_raddr = f_pos(r_slot, r_start, nk);
                            n_state  = S_WALK;
                        end
                    end
                    OP_MVX: begin
                        n_rvx  = q;
                        div_go = 1'b1;
                        div_a  = r_svy;
                        div_b  = STAMP_W'(r_fill - 1'b1);
                        div_op = OP_MVY;
                    end
                    OP_MVY: begin
                        n_rvy  = q;
                        div_go = 1'b1;
                        div_a  = r_sax;
                        div_b  = STAMP_W'(r_fill - 2'd2);
                        div_op = OP_MAX;
                    end
                    OP_MAX: begin
                        n_rax  = q;
                        div_go = 1'b1;
                        div_a  = r_say;
                        div_b  = STAMP_W'(r_fill - 2'd2);
                        div_op = OP_MAY;
                    end
                    OP_MAY: begin
                        n_ray    = q;
                        n_status = ST_ESTIMATE;
                        n_state  = S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end

            // Hand the result to the output register once it is free.
            S_FINISH: begin
                if (!r_o_valid || i_m_tready) begin
                    n_o_valid = 1'b1;
                    n_o_user  = r_status;
                    n_o_data  = {r_ray, r_rax, r_rvy, r_rvx};
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Load the divider with magnitudes; the sign is applied at the end.
        if (div_go) begin
            n_quo   = f_abs(div_a);
            n_neg   = div_a[VAL_W-1];
            n_rem   = '0;
            n_dvs   = div_b;
            n_cnt   = '0;
            n_op    = div_op;
            n_state = S_DIV;
        end
    end

endmodule

`default_nettype wire

[src/tve_checker.sv]
`default_nettype none

module tve_checker
    import tve_pkg::*;
(
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tvalid,
    input wire logic         o_s_tready,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [127:0] o_m_tdata,
    input wire logic [2:0]   o_m_tuser
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // Only an estimate carries nonzero means.
    a_zero_means: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_ESTIMATE |-> o_m_tdata == '0)
        else $error("means nonzero without an estimate");

    // An accepted event keeps the input closed for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input ready right after an event beat");

    // Reset empties the output.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind touch_velocity_estimator_core tve_checker u_tve_checker (.*);

`default_nettype wire

[bench/touch_velocity_estimator_core_tb.sv]
`default_nettype none

module touch_velocity_estimator_core_tb;
    import tve_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOUCHES   = 16;
    localparam int RING      = 8;
    localparam int MAX_CYCLES = 20_000_000;
    localparam int DRAIN_CYCLES = 1200;

    typedef struct {
        t_status     status;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] acc_x;
        logic [31:0] acc_y;
    } t_estimate;

    // Tracks the touch table and holds the result beats still to come.
    class touch_scoreboard;
        logic [9:0]  min_gap;
        bit          open_slot [TOUCHES];
        logic [15:0] open_id [TOUCHES];
        int          first [TOUCHES];
        int          fill [TOUCHES];
        logic [15:0] px [TOUCHES*RING];
        logic [15:0] py [TOUCHES*RING];
        logic [9:0]  pt [TOUCHES*RING];
        t_estimate   waiting [$];
        int          mismatches;

        function new();
            min_gap = MIN_INTERVAL_RST;
            mismatches = 0;
            foreach (open_slot[s]) begin
                open_slot[s] = 0;
            end
        endfunction

        function void set_min_gap(logic [9:0] v);
            min_gap = v;
        endfunction

        function int pending();
            return waiting.size();
        endfunction

        function int ms_between(logic [9:0] prev, logic [9:0] cur);
            int d;
            d = int'(cur) - int'(prev);
            if (d < 0) begin
                d += 1000;
            end
            if (d < 0) begin
                d += 1000;
            end
            return d;
        endfunction

        function int slot_pos(int s, int i);
            return s * RING + (first[s] + i) % RING;
        endfunction

        // Keeps a sample only if it is far enough from the newest kept one.
        function t_status keep_sample(int s, logic [15:0] x, logic [15:0] y, logic [9:0] t);
            int p;
            if (ms_between(pt[slot_pos(s, fill[s] - 1)], t) <= int'(min_gap)) begin
                return ST_THROTTLED;
            end
            if (fill[s] >= RING) begin
                first[s] = (first[s] + 1) % RING;
                fill[s] = RING - 1;
            end
            p = slot_pos(s, fill[s]);
            px[p] = x;
            py[p] = y;
            pt[p] = t;
            fill[s]++;
            return ST_KEPT;
        endfunction

        // Predicts the result beat of one accepted event beat.
        function void note_event(logic [1:0] mode, logic [15:0] id, logic [15:0] x,
                                 logic [15:0] y, logic [9:0] t);
            t_estimate e;
            int s;
            int n;
            longint svx, svy, sax, say, pvx, pvy, vx, vy, dt;
            s = -1;
            e.vel_x = '0;
            e.vel_y = '0;
            e.acc_x = '0;
            e.acc_y = '0;
            for (int i = TOUCHES - 1; i >= 0; i--) begin
                if (open_slot[i] && open_id[i] == id) begin
                    s = i;
                end
            end
            if (mode == MODE_DOWN) begin
                if (s >= 0) begin
                    e.status = ST_DUPLICATE;
                end else begin
                    for (int i = TOUCHES - 1; i >= 0; i--) begin
                        if (!open_slot[i]) begin
                            s = i;
                        end
                    end
                    if (s < 0) begin
                        e.status = ST_FULL;
                    end else begin
                        open_slot[s] = 1;
                        open_id[s] = id;
                        first[s] = 0;
                        fill[s] = 1;
                        px[s*RING] = x;
                        py[s*RING] = y;
                        pt[s*RING] = t;
                        e.status = ST_KEPT;
                    end
                end
            end else if (mode == MODE_MOVE) begin
                e.status = (s < 0) ? ST_UNKNOWN : keep_sample(s, x, y, t);
            end else if (mode == MODE_UP) begin
                if (s < 0) begin
                    e.status = ST_UNKNOWN;
                end else begin
                    void'(keep_sample(s, x, y, t));
                    n = fill[s];
                    if (n < 3) begin
                        e.status = ST_TOO_FEW;
                    end else begin
                        svx = 0; svy = 0; sax = 0; say = 0; pvx = 0; pvy = 0;
                        for (int k = 1; k < n; k++) begin
                            int a, b;
                            a = slot_pos(s, k - 1);
                            b = slot_pos(s, k);
                            dt = ms_between(pt[a], pt[b]);
                            if (dt <= 0) begin
                                dt = 1;
                            end
                            vx = ((longint'(px[b]) - longint'(px[a])) * 256) / dt;
                            vy = ((longint'(py[b]) - longint'(py[a])) * 256) / dt;
                            svx += vx;
                            svy += vy;
                            if (k >= 2) begin
                                sax += (vx - pvx) / dt;
                                say += (vy - pvy) / dt;
                            end
                            pvx = vx;
                            pvy = vy;
                        end
                        e.vel_x = 32'(svx / (n - 1));
                        e.vel_y = 32'(svy / (n - 1));
                        e.acc_x = 32'(sax / (n - 2));
                        e.acc_y = 32'(say / (n - 2));
                        e.status = ST_ESTIMATE;
                    end
                    open_slot[s] = 0;
                end
            end else begin
                e.status = ST_IGNORED;
            end
            waiting.push_back(e);
        endfunction

        // Compares one result beat with the oldest prediction.
        function void check_result(logic [2:0] status, logic [127:0] data);
            t_estimate e;
            if (waiting.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat: status %0d data %h", status, data);
                end
                return;
            end
            e = waiting.pop_front();
            if (status !== e.status || data[31:0] !== e.vel_x || data[63:32] !== e.vel_y
                || data[95:64] !== e.acc_x || data[127:96] !== e.acc_y) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected status %0d vx %h vy %h ax %h ay %h",
                             e.status, e.vel_x, e.vel_y, e.acc_x, e.acc_y);
                    $display("          actual   status %0d vx %h vy %h ax %h ay %h",
                             status, data[31:0], data[63:32], data[95:64], data[127:96]);
                end
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [63:0]  i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [127:0] o_m_tdata;
    logic [2:0]   o_m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    touch_scoreboard touches = new();
    int          cycle_count = 0;
    int          burst_left = 0;
    logic [9:0]  clock_ms = '0;
    logic [15:0] id_pool [20];

    touch_velocity_estimator_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Cycle counter with a timeout.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("touch_velocity_estimator_core_tb NOT OK");
            $finish;
        end
    end

    // Result side: check accepted beats and stall on a pattern of its own.
    int stall_phase = 0;
    int stall_style = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            touches.check_result(o_m_tuser, o_m_tdata);
        end
        if (stall_phase == 0) begin
            stall_style <= $urandom_range(2);
            stall_phase <= $urandom_range(40, 300);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_style)
            0: begin
                i_m_tready <= 1'b1;
            end
            1: begin
                i_m_tready <= $urandom_range(1);
            end
            default: begin
                i_m_tready <= ($urandom_range(15) == 0);
            end
        endcase
    end

    // Sends one event beat; the sender works in bursts with gaps between them.
    task automatic send_event(logic [1:0] mode, logic [15:0] id, logic [15:0] x,
                              logic [15:0] y, logic [9:0] t);
        i_s_tvalid <= 1'b1;
        i_s_tuser <= mode;
        i_s_tdata <= {6'd0, t, y, x, id};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        touches.note_event(mode, id, x, y, t);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(3) != 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 80)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Waits until every predicted beat has come back, then lets the core settle.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (touches.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_gap(logic [9:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_MIN_INTERVAL);
        pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        touches.set_min_gap(v);
    endtask

    task automatic random_phase(int count);
        int r;
        logic [15:0] id;
        logic [9:0] t;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            id = id_pool[$urandom_range(19)];
            clock_ms = 10'((int'(clock_ms) + $urandom_range(40)) % 1000);
            t = ($urandom_range(4) == 0) ? 10'($urandom_range(1023)) : clock_ms;
            if (r < 14) begin
                send_event(MODE_DOWN, id, 16'($urandom), 16'($urandom), t);
            end else if (r < 70) begin
                send_event(MODE_MOVE, id, 16'($urandom), 16'($urandom), t);
            end else if (r < 86) begin
                send_event(MODE_UP, id, 16'($urandom), 16'($urandom), t);
            end else if (r < 91) begin
                send_event(MODE_OTHER, id, 16'($urandom), 16'($urandom), t);
            end else begin
                send_event(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), t);
            end
            if (i == count / 2 && count > 100) begin
                drain_results();
            end
        end
    endtask

    initial begin
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        for (int i = 2; i < 20; i++) begin
            id_pool[i] = 16'($urandom);
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes, throttling, wrap, every status.
        send_event(MODE_DOWN, 16'h0000, 16'h0000, 16'h0000, 10'd990);
        send_event(MODE_MOVE, 16'h0000, 16'h0000, 16'h0000, 10'd995);
        send_event(MODE_MOVE, 16'h0000, 16'hFFFF, 16'hFFFF, 10'd5);
        send_event(MODE_MOVE, 16'h0000, 16'h0000, 16'hFFFF, 10'd1020);
        send_event(MODE_DOWN, 16'h0000, 16'h1234, 16'h1234, 10'd0);
        send_event(MODE_UP, 16'h0000, 16'hFFFF, 16'h0000, 10'd40);
        send_event(MODE_MOVE, 16'h0000, 16'h0001, 16'h0001, 10'd50);
        send_event(MODE_UP, 16'hFFFF, 16'h0001, 16'h0001, 10'd60);
        send_event(MODE_OTHER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1023);
        send_event(MODE_DOWN, 16'hFFFF, 16'h8000, 16'h8000, 10'd100);
        send_event(MODE_UP, 16'hFFFF, 16'h8001, 16'h7FFF, 10'd200);
        // Ring overflow, then an estimate over a full ring.
        send_event(MODE_DOWN, 16'h00AA, 16'h0000, 16'hFFFF, 10'd0);
        for (int i = 1; i <= 10; i++) begin
            send_event(MODE_MOVE, 16'h00AA, 16'(i * 6000), 16'(65535 - i * i * 600),
                       10'(i * 11));
        end
        send_event(MODE_UP, 16'h00AA, 16'hFFFF, 16'h0000, 10'd130);
        // Fill every slot, ask for one more, then release them all.
        for (int i = 0; i <= TOUCHES; i++) begin
            send_event(MODE_DOWN, 16'(i + 100), 16'(i), 16'(i), 10'd300);
        end
        for (int i = 0; i < TOUCHES; i++) begin
            send_event(MODE_UP, 16'(i + 100), 16'(i), 16'(i), 10'd400);
        end
        drain_results();

        // Random part across several interval settings.
        random_phase(500);
        drain_results();
        write_min_gap(10'd0);
        random_phase(500);
        drain_results();
        write_min_gap(10'd999);
        random_phase(200);
        drain_results();
        write_min_gap(10'($urandom_range(1, 60)));
        random_phase(400);
        drain_results();
        write_min_gap(10'd10);
        random_phase(300);

        drain_results();
        if (touches.mismatches == 0 && touches.pending() == 0) begin
            $display("touch_velocity_estimator_core_tb OK");
        end else begin
            $display("touch_velocity_estimator_core_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
src/tve_pkg.sv
src/touch_velocity_estimator_core.sv
src/tve_checker.sv
bench/touch_velocity_estimator_core_tb.sv
